>>> src/paa_pkg.sv
package paa_pkg;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int AREA_W = 56;
    localparam int SUM_W  = 64;
    localparam int COS_W  = 17;

    localparam int COS_DEPTH_DEF = 1024;

    // pi/2 in Q30, used to place the cosine table samples
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // (pi/180*R)^2 / 2 in Q4 square meters per Q40 square degree
    localparam logic [36:0] AREA_SCALE_Q4 = 37'd98970318493;

    // ceil(2^27 / 45): exact quotient for the table index range
    localparam logic [21:0] RECIP45       = 22'd2982617;
    localparam int          RECIP45_SHIFT = 27;

    // one vertex pair, as handed from the front to the back
    typedef struct packed {
        logic        has_pair;   // 0 on the first vertex of a polygon
        logic        neg;        // sign of the pair product
        logic [31:0] slon_mag;   // |lon1 + lon2|
        logic [29:0] dlat_mag;   // |lat2 - lat1|
        logic [30:0] lsum_mag;   // |lat1 + lat2|, selects the cosine
        logic        last;
        logic        closed;     // last vertex equals the first
    } t_pair;

endpackage

>>> src/paa_if.sv
interface paa_vtx_if;
    logic                              valid;
    logic                              ready;
    logic signed [paa_pkg::LAT_W-1:0]  point_lat;
    logic signed [paa_pkg::LON_W-1:0]  point_lon;
    logic                              last_point;

    modport source (output valid, point_lat, point_lon, last_point, input ready);
    modport sink   (input valid, point_lat, point_lon, last_point, output ready);
endinterface

interface paa_area_if;
    logic                        valid;
    logic                        ready;
    logic [paa_pkg::AREA_W-1:0]  area;

    modport source (output valid, area, input ready);
    modport sink   (input valid, area, output ready);
endinterface

>>> src/polygon_area_accumulator_core.sv
// Channel   Dir  Modport            Payload
// i_vtx     in   paa_vtx_if.sink    point_lat, point_lon, last_point
// o_area    out  paa_area_if.source area
//
// A vertex request passes through the back-end steps index, product, table
// read, term multiply and accumulate; a closing vertex adds scale and output
// load. The back-end sequencer, with its single cosine table port, takes a
// new vertex only once it is through with the last.
// The front end and a 2-deep queue take vertices while the back end works.
// Reset (i_rst_n low, synchronous) clears the queue, the sequencer, the
// accumulator and the first/previous vertex state; no clearing pass.
// A stalled area request holds the back end in its output step only.
module polygon_area_accumulator_core import paa_pkg::*; #(
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    paa_vtx_if.sink    i_vtx,
    paa_area_if.source o_area
);

    logic  w_push_valid;
    logic  w_push_ready;
    t_pair w_push_data;
    logic  w_pop_valid;
    logic  w_pop_ready;
    t_pair w_pop_data;

    // front: vertex bookkeeping and pair classification
    paa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (i_vtx),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // short queue decoupling the two halves
    paa_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // back: cosine-weighted term, accumulation, final scale and saturation
    paa_back #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_area      (o_area)
    );

endmodule

>>> src/paa_front.sv
module paa_front import paa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    paa_vtx_if.sink    i_vtx,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_pair      o_push_data
);

    logic signed [LAT_W-1:0] r_first_lat;
    logic signed [LON_W-1:0] r_first_lon;
    logic signed [LAT_W-1:0] r_prev_lat;
    logic signed [LON_W-1:0] r_prev_lon;
    logic                    r_have_prev;

    logic        w_fire;
    logic [31:0] w_slon;
    logic [30:0] w_dlat;
    logic [30:0] w_lsum;
    logic [31:0] w_dlat_mag;

    assign i_vtx.ready  = i_push_ready;
    assign o_push_valid = i_vtx.valid;
    assign w_fire       = i_vtx.valid && i_push_ready;

    assign w_slon = {r_prev_lon[LON_W-1], r_prev_lon}
                  + {i_vtx.point_lon[LON_W-1], i_vtx.point_lon};
    assign w_dlat = {i_vtx.point_lat[LAT_W-1], i_vtx.point_lat}
                  - {r_prev_lat[LAT_W-1], r_prev_lat};
    assign w_lsum = {r_prev_lat[LAT_W-1], r_prev_lat}
                  + {i_vtx.point_lat[LAT_W-1], i_vtx.point_lat};
    assign w_dlat_mag = w_dlat[30] ? 32'(-w_dlat) : 32'(w_dlat);

    always_comb begin
        o_push_data.has_pair = r_have_prev;
        o_push_data.neg      = w_slon[31] ^ w_dlat[30];
        o_push_data.slon_mag = w_slon[31] ? -w_slon : w_slon;
        o_push_data.dlat_mag = w_dlat_mag[29:0];
        o_push_data.lsum_mag = w_lsum[30] ? -w_lsum : w_lsum;
        o_push_data.last     = i_vtx.last_point;
        // a lone vertex closes on itself
        o_push_data.closed   = !r_have_prev ||
                               (i_vtx.point_lat == r_first_lat &&
                                i_vtx.point_lon == r_first_lon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_first_lat <= '0;
            r_first_lon <= '0;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
        end else if (w_fire) begin
            if (!r_have_prev) begin
                r_first_lat <= i_vtx.point_lat;
                r_first_lon <= i_vtx.point_lon;
            end
            r_prev_lat  <= i_vtx.point_lat;
            r_prev_lon  <= i_vtx.point_lon;
            r_have_prev <= !i_vtx.last_point;
        end
    end

endmodule

>>> src/paa_fifo.sv
module paa_fifo import paa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_pair i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_pair o_pop_data
);

    t_pair      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_cnt_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count missed a push");

endmodule

>>> src/paa_back.sv
module paa_back import paa_pkg::*; #(
    parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_pair      i_pop_data,
    paa_area_if.source o_area
);

    localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int NW = 31 + $clog2(COS_TABLE_DEPTH + 1) + 1;
    localparam int QW = NW - 24;
    localparam int EW = QW + 22;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ROM  = 3'd2;
    localparam logic [2:0] S_TERM = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_SCL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // cosine table, Q16, entry i = cos(90 deg * i / depth)
    logic [COS_W-1:0] w_cos_rom [0:COS_TABLE_DEPTH];

    for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_cos
        localparam longint unsigned X  =
            (HALF_PI_Q30 * longint'(gi) + longint'(COS_TABLE_DEPTH / 2))
            / longint'(COS_TABLE_DEPTH);
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((ONE_Q30 * X2) >> 30) / 2;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 12;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 30;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 56;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 90;
        localparam longint unsigned T6 = ((T5 * X2) >> 30) / 132;
        localparam longint unsigned T7 = ((T6 * X2) >> 30) / 182;
        localparam longint unsigned T8 = ((T7 * X2) >> 30) / 240;
        localparam longint unsigned T9 = ((T8 * X2) >> 30) / 306;
        localparam longint unsigned T10 = ((T9 * X2) >> 30) / 380;
        localparam longint SUMC = longint'(ONE_Q30) - longint'(T1) + longint'(T2)
            - longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6)
            - longint'(T7) + longint'(T8) - longint'(T9) + longint'(T10);
        localparam longint CL = (SUMC < 0) ? 0 :
                                (SUMC > longint'(ONE_Q30)) ? longint'(ONE_Q30) : SUMC;
        localparam longint Q16 = (CL + 8192) >>> 14;
        assign w_cos_rom[gi] = COS_W'(Q16);
    end

    logic [2:0]       r_state;
    t_pair            r_e;
    logic [QW-1:0]    r_q;
    logic [IW-1:0]    r_idx;
    logic [61:0]      r_p;
    logic [COS_W-1:0] r_cos;
    logic [46:0]      r_thi;
    logic [48:0]      r_tlo;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_a;
    logic [68:0]      r_pp0;
    logic [68:0]      r_pp1;
    logic             r_oval;
    logic [AREA_W-1:0] r_area;

    logic [NW-1:0]     w_num;
    logic [EW-1:0]     w_qm;
    logic [EW-RECIP45_SHIFT-1:0] w_est;
    logic [SUM_W-1:0]  w_t;
    logic [SUM_W-1:0]  n_sum;
    logic [100:0]      w_prod;
    logic [AREA_W-1:0] w_scaled;

    assign o_pop_ready  = (r_state == S_IDLE);
    assign o_area.valid = r_oval;
    assign o_area.area  = r_area;

    // index = round(|lat sum| * depth / (180 * 2^22)); divide by 2^24 then by 45
    assign w_num = NW'(i_pop_data.lsum_mag) * NW'(COS_TABLE_DEPTH) + NW'(45 << 23);
    assign w_qm  = EW'(r_q) * EW'(RECIP45);
    assign w_est = w_qm[EW-1:RECIP45_SHIFT];

    assign w_t = 64'({r_thi, 12'b0}) + 64'(r_tlo[48:20]);

    always_comb begin
        if (!r_e.has_pair) begin
            n_sum = '0;
        end else if (r_e.neg) begin
            n_sum = r_sum - w_t;
        end else begin
            n_sum = r_sum + w_t;
        end
    end

    assign w_prod   = 101'(r_pp0) + {r_pp1, 32'b0};
    assign w_scaled = (|w_prod[100:96]) ? {AREA_W{1'b1}} : w_prod[95:40];

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_e <= i_pop_data;
                r_q <= w_num[NW-1:24];
            end
            S_MUL: begin
                r_idx <= (w_est > (EW-RECIP45_SHIFT)'(COS_TABLE_DEPTH))
                       ? IW'(COS_TABLE_DEPTH) : w_est[IW-1:0];
                r_p   <= 62'(r_e.slon_mag) * 62'(r_e.dlat_mag);
            end
            S_ROM: begin
                r_cos <= w_cos_rom[r_idx];
            end
            S_TERM: begin
                r_thi <= 47'(r_p[61:32]) * 47'(r_cos);
                r_tlo <= 49'(r_p[31:0]) * 49'(r_cos);
            end
            S_ACC: begin
                r_a <= n_sum[SUM_W-1] ? -n_sum : n_sum;
            end
            S_SCL: begin
                r_pp0 <= 69'(r_a[31:0]) * 69'(AREA_SCALE_Q4);
                r_pp1 <= 69'(r_a[63:32]) * 69'(AREA_SCALE_Q4);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_oval  <= 1'b0;
            r_area  <= '0;
        end else begin
            // the output step reloads the register itself
            if (r_oval && o_area.ready && r_state != S_OUT) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_ROM;
                S_ROM:  r_state <= S_TERM;
                S_TERM: r_state <= S_ACC;
                S_ACC: begin
                    if (r_e.last) begin
                        r_sum   <= '0;
                        r_state <= S_SCL;
                    end else begin
                        r_sum   <= n_sum;
                        r_state <= S_IDLE;
                    end
                end
                S_SCL:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_oval || o_area.ready) begin
                        r_oval  <= 1'b1;
                        r_area  <= r_e.closed ? w_scaled : '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROM) |-> (r_idx <= IW'(COS_TABLE_DEPTH)))
        else $error("cosine index past table end");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_e.last) |=> (r_sum == '0 && r_state == S_SCL))
        else $error("accumulator not cleared at polygon end");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(r_state) == S_OUT)
        else $error("result shown outside the output step");

endmodule
